// ===== src/ledseq_pkg.sv =====
// shared types and constants for the rgb led blink and flash sequencer
// no dependencies
package ledseq_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned LevelW = 8;
  localparam int unsigned CountW = 8;
  localparam int unsigned FuncW  = 3;
  localparam int unsigned IdxW   = 2;
  localparam int unsigned InDataW  = 104;
  localparam int unsigned OutDataW = 32;

  localparam logic [FuncW-1:0] FUNC_TICK  = 3'd0;
  localparam logic [FuncW-1:0] FUNC_COLOR = 3'd1;
  localparam logic [FuncW-1:0] FUNC_FLASH = 3'd2;
  localparam logic [FuncW-1:0] FUNC_BLINK = 3'd3;
  localparam logic [FuncW-1:0] FUNC_OFF   = 3'd4;

  localparam logic [IdxW-1:0] REG_BLINK_ON  = 2'd0;
  localparam logic [IdxW-1:0] REG_BLINK_OFF = 2'd1;
  localparam logic [IdxW-1:0] REG_COOLDOWN  = 2'd2;

  localparam logic [CfgW-1:0] BLINK_ON_RESET  = 16'd100;
  localparam logic [CfgW-1:0] BLINK_OFF_RESET = 16'd400;
  localparam logic [CfgW-1:0] COOLDOWN_RESET  = 16'd2000;

  typedef struct packed {
    logic [CfgW-1:0] blink_on_ms;
    logic [CfgW:0]   on_plus_off;
    logic [CfgW-1:0] cooldown_ms;
  } cfg_t;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [TimeW-1:0]  now_ms;
    logic [LevelW-1:0] red;
    logic [LevelW-1:0] green;
    logic [LevelW-1:0] blue;
    logic [TimeW-1:0]  duration_ms;
    logic [CountW-1:0] count;
    logic              continuous;
  } cmd_t;

  typedef struct packed {
    logic [LevelW-1:0] red_drive;
    logic [LevelW-1:0] green_drive;
    logic [LevelW-1:0] blue_drive;
    logic              busy_res;
  } res_t;

endpackage

// ===== src/ledseq_cfg.sv =====
// timing registers of the led sequencer, written through the plain write port
// depends on ledseq_pkg
module ledseq_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [ledseq_pkg::IdxW-1:0] cfg_index,
  input  logic [ledseq_pkg::CfgW-1:0] cfg_data,
  output ledseq_pkg::cfg_t           cfg
);

  logic [ledseq_pkg::CfgW-1:0] blink_on_ms;
  logic [ledseq_pkg::CfgW-1:0] blink_off_ms;
  logic [ledseq_pkg::CfgW-1:0] cooldown_ms;
  logic [ledseq_pkg::CfgW:0]   on_plus_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_on_ms  <= ledseq_pkg::BLINK_ON_RESET;
      blink_off_ms <= ledseq_pkg::BLINK_OFF_RESET;
      cooldown_ms  <= ledseq_pkg::COOLDOWN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        ledseq_pkg::REG_BLINK_ON:  blink_on_ms  <= cfg_data;
        ledseq_pkg::REG_BLINK_OFF: blink_off_ms <= cfg_data;
        ledseq_pkg::REG_COOLDOWN:  cooldown_ms  <= cfg_data;
        default: ;
      endcase
    end
  end

  // end of the dark phase, kept as a sum so the tick path needs only compares
  always_comb begin
    on_plus_off = {1'b0, blink_on_ms} + {1'b0, blink_off_ms};
  end

  assign cfg.blink_on_ms = blink_on_ms;
  assign cfg.on_plus_off = on_plus_off;
  assign cfg.cooldown_ms = cooldown_ms;

endmodule

// ===== src/ledseq_core.sv =====
// pattern state of the led sequencer and its per-command update
// depends on ledseq_pkg
module ledseq_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  ledseq_pkg::cmd_t  cmd,
  input  ledseq_pkg::cfg_t  cfg,
  output ledseq_pkg::res_t  res
);

  logic [ledseq_pkg::LevelW-1:0] colour_red, colour_red_next;
  logic [ledseq_pkg::LevelW-1:0] colour_green, colour_green_next;
  logic [ledseq_pkg::LevelW-1:0] colour_blue, colour_blue_next;
  logic                          pattern_active, pattern_active_next;
  logic                          lit, lit_next;
  logic [ledseq_pkg::TimeW-1:0]  phase_start, phase_start_next;
  logic [ledseq_pkg::TimeW-1:0]  flash_length, flash_length_next;
  logic [ledseq_pkg::CountW-1:0] burst_size, burst_size_next;
  logic [ledseq_pkg::CountW-1:0] blinks_left, blinks_left_next;
  logic                          repeat_bursts, repeat_bursts_next;
  logic [ledseq_pkg::TimeW-1:0]  delta;

  always_comb begin
    delta = cmd.now_ms - phase_start;
    colour_red_next     = colour_red;
    colour_green_next   = colour_green;
    colour_blue_next    = colour_blue;
    pattern_active_next = pattern_active;
    lit_next            = lit;
    phase_start_next    = phase_start;
    flash_length_next   = flash_length;
    burst_size_next     = burst_size;
    blinks_left_next    = blinks_left;
    repeat_bursts_next  = repeat_bursts;
    case (cmd.func)
      ledseq_pkg::FUNC_TICK: begin
        if (pattern_active) begin
          if (blinks_left != '0) begin
            if (delta < {16'd0, cfg.blink_on_ms}) begin
              lit_next = 1'b1;
            end else begin
              lit_next = 1'b0;
              // delta is at least the on time here, so this is the off-time test
              if (delta > {15'd0, cfg.on_plus_off}) begin
                phase_start_next = cmd.now_ms;
                blinks_left_next = blinks_left - 8'd1;
                if (blinks_left == 8'd1 && !repeat_bursts) begin
                  pattern_active_next = 1'b0;
                end
              end
            end
          end else if (burst_size != '0 && repeat_bursts) begin
            if (delta > {16'd0, cfg.cooldown_ms}) begin
              phase_start_next = cmd.now_ms;
              blinks_left_next = burst_size;
            end
          end else if (flash_length != '0 && delta >= flash_length) begin
            pattern_active_next = 1'b0;
            lit_next            = 1'b0;
          end
        end
      end
      ledseq_pkg::FUNC_COLOR: begin
        colour_red_next   = cmd.red;
        colour_green_next = cmd.green;
        colour_blue_next  = cmd.blue;
        lit_next          = pattern_active;
      end
      ledseq_pkg::FUNC_FLASH: begin
        // a running flash is not restarted
        if (!(pattern_active && burst_size == '0)) begin
          pattern_active_next = 1'b1;
          phase_start_next    = cmd.now_ms;
          flash_length_next   = cmd.duration_ms;
          burst_size_next     = '0;
          blinks_left_next    = '0;
          repeat_bursts_next  = 1'b0;
          lit_next            = 1'b1;
        end
      end
      ledseq_pkg::FUNC_BLINK: begin
        if (pattern_active && cmd.count == '0) begin
          pattern_active_next = 1'b0;
          lit_next            = 1'b0;
        end else if (pattern_active) begin
          repeat_bursts_next = cmd.continuous;
          burst_size_next    = cmd.count;
          if (blinks_left > cmd.count) begin
            blinks_left_next = cmd.count;
          end
        end else begin
          pattern_active_next = 1'b1;
          phase_start_next    = cmd.now_ms;
          flash_length_next   = '0;
          burst_size_next     = cmd.count;
          blinks_left_next    = cmd.count;
          repeat_bursts_next  = cmd.continuous;
          lit_next            = 1'b1;
        end
      end
      ledseq_pkg::FUNC_OFF: begin
        pattern_active_next = 1'b0;
        lit_next            = 1'b0;
      end
      default: ;
    endcase
    // the blink burst end above clears lit as well
    if (!pattern_active_next) begin
      lit_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      colour_red     <= '0;
      colour_green   <= '0;
      colour_blue    <= '0;
      pattern_active <= 1'b0;
      lit            <= 1'b0;
      phase_start    <= '0;
      flash_length   <= '0;
      burst_size     <= '0;
      blinks_left    <= '0;
      repeat_bursts  <= 1'b0;
    end else if (step) begin
      colour_red     <= colour_red_next;
      colour_green   <= colour_green_next;
      colour_blue    <= colour_blue_next;
      pattern_active <= pattern_active_next;
      lit            <= lit_next;
      phase_start    <= phase_start_next;
      flash_length   <= flash_length_next;
      burst_size     <= burst_size_next;
      blinks_left    <= blinks_left_next;
      repeat_bursts  <= repeat_bursts_next;
    end
  end

  assign res.red_drive   = lit_next ? colour_red_next : '0;
  assign res.green_drive = lit_next ? colour_green_next : '0;
  assign res.blue_drive  = lit_next ? colour_blue_next : '0;
  assign res.busy_res    = pattern_active_next;

endmodule

// ===== src/rgb_led_blink_flash_sequencer_top.sv =====
// top level of the rgb led blink and flash sequencer: stream ports and pipeline registers
// depends on ledseq_pkg, ledseq_cfg, ledseq_core
//
// Each command (tick, set colour, flash, blink, turn off) carries the current
// millisecond time and gives exactly one result: the RGB drive after the command
// and a busy flag. A command is captured in an input register; the state update
// and the result are then worked out in one pass and written into the output
// register, and one command is taken every cycle; the only limit on throughput
// is the output side taking results.
// Timing registers are written through cfg_we/cfg_index/cfg_data; the user must write them while idle, unenforced here.
module rgb_led_blink_flash_sequencer_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // now_ms[31:0], red[39:32], green[47:40], blue[55:48], duration_ms[87:56],
  // count[95:88], continuous[96], zero fill
  input  logic [ledseq_pkg::InDataW-1:0]    s_axis_tdata,
  // func[2:0]
  input  logic [ledseq_pkg::FuncW-1:0]      s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // red_drive[7:0], green_drive[15:8], blue_drive[23:16], busy_res[24], zero fill
  output logic [ledseq_pkg::OutDataW-1:0]   m_axis_tdata,
  input  logic                              cfg_we,
  input  logic [ledseq_pkg::IdxW-1:0]       cfg_index,
  input  logic [ledseq_pkg::CfgW-1:0]       cfg_data
);

  ledseq_pkg::cfg_t cfg;
  ledseq_pkg::cmd_t cmd;
  ledseq_pkg::res_t res;
  ledseq_pkg::res_t out_res;
  logic             in_valid;
  logic             out_valid;
  logic             advance;
  logic             step;

  assign advance       = !out_valid || m_axis_tready;
  assign step          = in_valid && advance;
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd.func        <= s_axis_tuser;
      cmd.now_ms      <= s_axis_tdata[31:0];
      cmd.red         <= s_axis_tdata[39:32];
      cmd.green       <= s_axis_tdata[47:40];
      cmd.blue        <= s_axis_tdata[55:48];
      cmd.duration_ms <= s_axis_tdata[87:56];
      cmd.count       <= s_axis_tdata[95:88];
      cmd.continuous  <= s_axis_tdata[96];
    end
    if (step) begin
      out_res <= res;
    end
  end

  ledseq_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ledseq_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .cmd  (cmd),
    .cfg  (cfg),
    .res  (res)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, out_res.busy_res, out_res.blue_drive,
                          out_res.green_drive, out_res.red_drive};

`ifndef NO_ASSERTIONS
  // a lit led always belongs to an active pattern
  a_drive_needs_busy: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[23:0] != 24'd0) |-> m_axis_tdata[24])
    else $error("nonzero drive reported while not busy");

  // an empty input register never blocks the slave side
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_axis_tready)
    else $error("input stalled with empty input register");

  // a held command moves to the output when the output side is free
  a_command_moves: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |=> out_valid)
    else $error("command not passed to output register");
`endif

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for rgb_led_blink_flash_sequencer_top: directed and random commands
// are checked against an in-bench model of the blink and flash sequencer
// depends on ledseq_pkg and the rtl of rgb_led_blink_flash_sequencer_top
module testbench;

  localparam int unsigned LATENCY = 2;
  localparam int unsigned CYCLE_LIMIT = 250000;
  localparam int unsigned ITEMS_PER_SETTING = 215;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [ledseq_pkg::InDataW-1:0] s_axis_tdata;
  logic [ledseq_pkg::FuncW-1:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [ledseq_pkg::OutDataW-1:0] m_axis_tdata;
  logic cfg_we;
  logic [ledseq_pkg::IdxW-1:0] cfg_index;
  logic [ledseq_pkg::CfgW-1:0] cfg_data;

  // sequencer model state
  logic [ledseq_pkg::CfgW-1:0] on_ms, off_ms, cool_ms;
  logic [ledseq_pkg::LevelW-1:0] col_r, col_g, col_b;
  bit pat_on, led_lit, rep;
  logic [ledseq_pkg::TimeW-1:0] seg_start, flash_len;
  logic [ledseq_pkg::CountW-1:0] burst_len, left;

  ledseq_pkg::res_t drive_q[$];
  ledseq_pkg::res_t want;
  logic [ledseq_pkg::TimeW-1:0] clock_ms;
  bit tx_idle, rx_idle;
  int unsigned hold_req;
  int unsigned cycle_count = 0;
  int unsigned n_sent, n_effective, n_checked, n_writes, n_settings, n_errors;

  rgb_led_blink_flash_sequencer_top dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL rgb_led_blink_flash_sequencer_top");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] exp_v);
    n_errors++;
    if (n_errors <= 50)
      $display("mismatch at cycle %0d: %s got 0x%0h expected 0x%0h", cycle_count, what, got,
               exp_v);
  endtask

  function automatic void go_idle();
    if (pat_on) begin
      pat_on = 1'b0;
      led_lit = 1'b0;
    end
  endfunction

  // applies one command to the model and returns the drive it leaves behind
  function automatic ledseq_pkg::res_t led_model_step(input ledseq_pkg::cmd_t c);
    ledseq_pkg::res_t r;
    logic [ledseq_pkg::TimeW-1:0] delta;
    case (c.func)
      ledseq_pkg::FUNC_TICK: begin
        if (pat_on) begin
          delta = c.now_ms - seg_start;
          if (left != 0) begin
            if (delta < 32'(on_ms)) begin
              led_lit = 1'b1;
            end else begin
              led_lit = 1'b0;
              if (delta - 32'(on_ms) > 32'(off_ms)) begin
                seg_start = c.now_ms;
                left = left - 8'd1;
                if (left == 0 && !rep) go_idle();
              end
            end
          end else if (burst_len != 0 && rep) begin
            if (delta > 32'(cool_ms)) begin
              seg_start = c.now_ms;
              left = burst_len;
            end
          end else if (flash_len != 0 && delta >= flash_len) begin
            go_idle();
          end
        end
      end
      ledseq_pkg::FUNC_COLOR: begin
        col_r = c.red;
        col_g = c.green;
        col_b = c.blue;
        led_lit = pat_on;
      end
      ledseq_pkg::FUNC_FLASH: begin
        // a running flash is not restarted
        if (!(pat_on && burst_len == 0)) begin
          pat_on = 1'b1;
          seg_start = c.now_ms;
          flash_len = c.duration_ms;
          burst_len = '0;
          left = '0;
          rep = 1'b0;
          led_lit = 1'b1;
        end
      end
      ledseq_pkg::FUNC_BLINK: begin
        if (pat_on && c.count == 0) begin
          go_idle();
        end else if (pat_on) begin
          rep = c.continuous;
          burst_len = c.count;
          if (left > c.count) left = c.count;
        end else begin
          pat_on = 1'b1;
          seg_start = c.now_ms;
          flash_len = '0;
          burst_len = c.count;
          left = c.count;
          rep = c.continuous;
          led_lit = 1'b1;
        end
      end
      ledseq_pkg::FUNC_OFF: go_idle();
      default: ;
    endcase
    r.red_drive = led_lit ? col_r : '0;
    r.green_drive = led_lit ? col_g : '0;
    r.blue_drive = led_lit ? col_b : '0;
    r.busy_res = pat_on;
    return r;
  endfunction

  function automatic ledseq_pkg::cmd_t rand_cmd(input logic [ledseq_pkg::FuncW-1:0] f,
                                                input logic [ledseq_pkg::TimeW-1:0] t);
    ledseq_pkg::cmd_t c;
    c.func = f;
    c.now_ms = t;
    c.red = 8'($urandom);
    c.green = 8'($urandom);
    c.blue = 8'($urandom);
    c.duration_ms = $urandom;
    c.count = 8'($urandom);
    c.continuous = 1'($urandom);
    return c;
  endfunction

  task automatic issue_cmd(input ledseq_pkg::cmd_t c);
    int unsigned gap;
    gap = tx_idle ? $urandom_range(0, 8) : 0;
    if (gap != 0) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {7'd0, c.continuous, c.count, c.duration_ms, c.blue, c.green, c.red,
                     c.now_ms};
    s_axis_tuser <= c.func;
    do @(posedge clk); while (!s_axis_tready);
    if ((c.func >= ledseq_pkg::FUNC_COLOR && c.func <= ledseq_pkg::FUNC_BLINK) ||
        (pat_on && (c.func == ledseq_pkg::FUNC_TICK || c.func == ledseq_pkg::FUNC_OFF)))
      n_effective++;
    n_sent++;
    drive_q.push_back(led_model_step(c));
  endtask

  // stop sending, let every pending result come out, then allow for the pipeline
  task automatic settle_block();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (drive_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ledseq_pkg::IdxW-1:0] idx,
                           input logic [ledseq_pkg::CfgW-1:0] val);
    settle_block();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      ledseq_pkg::REG_BLINK_ON: on_ms = val;
      ledseq_pkg::REG_BLINK_OFF: off_ms = val;
      ledseq_pkg::REG_COOLDOWN: cool_ms = val;
      default: ;
    endcase
    n_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // one flash or blink pattern followed by ticks and stray commands
  task automatic run_pattern(input bit vary_idle);
    ledseq_pkg::cmd_t c;
    int unsigned span, pick, n_steps;
    if (vary_idle) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
    end
    span = (32'(on_ms) + 32'(off_ms) + 32'(cool_ms)) / 3 + 2;
    case ($urandom_range(0, 7))
      0: clock_ms = $urandom;
      1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, span);
      default: ;
    endcase
    if ($urandom_range(0, 9) < 4) begin
      c = rand_cmd(ledseq_pkg::FUNC_FLASH, clock_ms);
      case ($urandom_range(0, 7))
        0: c.duration_ms = '0;
        1: c.duration_ms = '1;
        2: ;
        default: c.duration_ms = $urandom_range(1, 4 * span);
      endcase
    end else begin
      c = rand_cmd(ledseq_pkg::FUNC_BLINK, clock_ms);
      case ($urandom_range(0, 15))
        0: c.count = '0;
        1: c.count = '1;
        2: ;
        default: c.count = 8'($urandom_range(1, 4));
      endcase
    end
    issue_cmd(c);
    n_steps = $urandom_range(8, 30);
    repeat (n_steps) begin
      // land on phase boundaries now and then, otherwise drift forward
      case ($urandom_range(0, 15))
        0: clock_ms = seg_start + on_ms - 1;
        1: clock_ms = seg_start + on_ms;
        2: clock_ms = seg_start + on_ms + off_ms;
        3: clock_ms = seg_start + on_ms + off_ms + 1;
        4: clock_ms = seg_start + cool_ms;
        5: clock_ms = seg_start + cool_ms + 1;
        6: clock_ms = seg_start + flash_len - 1;
        7: clock_ms = seg_start + flash_len;
        default: clock_ms = clock_ms + $urandom_range(0, span);
      endcase
      pick = $urandom_range(0, 31);
      if (pick < 24) begin
        c = rand_cmd(ledseq_pkg::FUNC_TICK, clock_ms);
      end else if (pick < 26) begin
        c = rand_cmd(ledseq_pkg::FUNC_COLOR, clock_ms);
      end else if (pick < 28) begin
        c = rand_cmd(ledseq_pkg::FUNC_BLINK, clock_ms);
        if (pick == 26) c.count = 8'($urandom_range(0, 5));
      end else if (pick == 28) begin
        c = rand_cmd(ledseq_pkg::FUNC_FLASH, clock_ms);
      end else if (pick == 29) begin
        c = rand_cmd(ledseq_pkg::FUNC_OFF, clock_ms);
      end else begin
        c = rand_cmd(ledseq_pkg::FUNC_OFF + 3'($urandom_range(1, 3)), clock_ms);
      end
      issue_cmd(c);
    end
  endtask

  task automatic test_directed();
    ledseq_pkg::cmd_t c;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    // idle tick, idle turn off and the spare codes change nothing
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_TICK, 32'd0));
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_OFF, 32'd5));
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_OFF + 3'd1, 32'd6));
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_OFF + 3'd3, 32'hFFFF_FFFF));
    c = rand_cmd(ledseq_pkg::FUNC_COLOR, 32'd7);
    c.red = '1; c.green = '1; c.blue = '1;
    issue_cmd(c);
    c = rand_cmd(ledseq_pkg::FUNC_FLASH, 32'd10);
    c.duration_ms = '0;
    issue_cmd(c);
    c = rand_cmd(ledseq_pkg::FUNC_FLASH, 32'd20);
    c.duration_ms = 32'd5;
    issue_cmd(c);
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_TICK, 32'd100000));
    c = rand_cmd(ledseq_pkg::FUNC_COLOR, 32'd100001);
    c.red = '0; c.green = '0; c.blue = '0;
    issue_cmd(c);
    c = rand_cmd(ledseq_pkg::FUNC_COLOR, 32'd100001);
    c.red = 8'h12; c.green = 8'h34; c.blue = 8'h56;
    issue_cmd(c);
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_OFF, 32'd100002));
    // flash ends once the elapsed time reaches its length
    c = rand_cmd(ledseq_pkg::FUNC_FLASH, 32'd200);
    c.duration_ms = 32'd50;
    issue_cmd(c);
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_TICK, 32'd249));
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_TICK, 32'd250));
    // blink of zero count: on while idle, off while active
    c = rand_cmd(ledseq_pkg::FUNC_BLINK, 32'd300);
    c.count = '0;
    issue_cmd(c);
    c = rand_cmd(ledseq_pkg::FUNC_BLINK, 32'd301);
    c.count = '0;
    issue_cmd(c);
    c = rand_cmd(ledseq_pkg::FUNC_BLINK, 32'd1000);
    c.count = 8'd3; c.continuous = 1'b1;
    issue_cmd(c);
    c = rand_cmd(ledseq_pkg::FUNC_BLINK, 32'd1001);
    c.count = 8'd5; c.continuous = 1'b0;
    issue_cmd(c);
    c = rand_cmd(ledseq_pkg::FUNC_BLINK, 32'd1002);
    c.count = 8'd1; c.continuous = 1'b1;
    issue_cmd(c);
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_TICK, 32'd1099));
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_TICK, 32'd1100));
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_TICK, 32'd1500));
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_TICK, 32'd1501));
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_TICK, 32'd3501));
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_TICK, 32'd3502));
    // flash replaces a blink, elapsed time wraps past zero
    c = rand_cmd(ledseq_pkg::FUNC_FLASH, 32'hFFFF_FFFF);
    c.duration_ms = '1;
    issue_cmd(c);
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_TICK, 32'hFFFF_FFFE));
    c = rand_cmd(ledseq_pkg::FUNC_BLINK, 32'd0);
    c.count = '1; c.continuous = 1'b1;
    issue_cmd(c);
    issue_cmd(rand_cmd(ledseq_pkg::FUNC_OFF, 32'd1));
    n_settings++;
  endtask

  task automatic test_backpressure();
    write_reg(ledseq_pkg::REG_BLINK_ON, 16'd3);
    write_reg(ledseq_pkg::REG_BLINK_OFF, 16'd4);
    write_reg(ledseq_pkg::REG_COOLDOWN, 16'd6);
    n_settings++;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_req = 200;
    repeat (3) run_pattern(1'b0);
  endtask

  task automatic test_timing_sweep();
    logic [ledseq_pkg::CfgW-1:0] on_v, off_v, cool_v;
    int unsigned goal;
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin on_v = 16'd3; off_v = 16'd4; cool_v = 16'd6; end
        1: begin on_v = 16'd1; off_v = 16'd0; cool_v = 16'd0; end
        2: begin on_v = 16'd10; off_v = 16'd20; cool_v = 16'd50; end
        3: begin on_v = '1; off_v = '1; cool_v = '1; end
        4: begin on_v = 16'd1; off_v = '1; cool_v = 16'd0; end
        7: begin
          on_v = 16'($urandom_range(1, 65535));
          off_v = 16'($urandom);
          cool_v = 16'($urandom);
        end
        default: begin
          on_v = 16'($urandom_range(1, 40));
          off_v = 16'($urandom_range(0, 60));
          cool_v = 16'($urandom_range(0, 100));
        end
      endcase
      write_reg(ledseq_pkg::REG_BLINK_ON, on_v);
      write_reg(ledseq_pkg::REG_BLINK_OFF, off_v);
      write_reg(ledseq_pkg::REG_COOLDOWN, cool_v);
      n_settings++;
      goal = n_sent + ITEMS_PER_SETTING;
      while (n_sent < goal) run_pattern(1'b1);
    end
  endtask

  // result side: random stalls per transaction, plus a long hold-off on request
  initial begin
    int unsigned stall_left, hold_left;
    bit took;
    m_axis_tready = 1'b0;
    stall_left = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      took = m_axis_tvalid && m_axis_tready;
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (took) stall_left = rx_idle ? $urandom_range(0, 8) : 0;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      n_checked++;
      if (drive_q.size() == 0) begin
        flag_mismatch("result with nothing pending", m_axis_tdata, '0);
      end else begin
        want = drive_q.pop_front();
        if (m_axis_tdata[7:0] !== want.red_drive)
          flag_mismatch("red_drive", 32'(m_axis_tdata[7:0]), 32'(want.red_drive));
        if (m_axis_tdata[15:8] !== want.green_drive)
          flag_mismatch("green_drive", 32'(m_axis_tdata[15:8]), 32'(want.green_drive));
        if (m_axis_tdata[23:16] !== want.blue_drive)
          flag_mismatch("blue_drive", 32'(m_axis_tdata[23:16]), 32'(want.blue_drive));
        if (m_axis_tdata[24] !== want.busy_res)
          flag_mismatch("busy_res", 32'(m_axis_tdata[24]), 32'(want.busy_res));
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    hold_req = 0;
    clock_ms = '0;
    on_ms = ledseq_pkg::BLINK_ON_RESET;
    off_ms = ledseq_pkg::BLINK_OFF_RESET;
    cool_ms = ledseq_pkg::COOLDOWN_RESET;
    col_r = '0; col_g = '0; col_b = '0;
    pat_on = 1'b0; led_lit = 1'b0; rep = 1'b0;
    seg_start = '0; flash_len = '0;
    burst_len = '0; left = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_timing_sweep();
    settle_block();
    $display("covered %0d commands (%0d acting on the pattern or colour), %0d results checked",
             n_sent, n_effective, n_checked);
    $display("timing registers written %0d times over %0d settings, extremes included",
             n_writes, n_settings);
    if (n_errors == 0) begin
      $display("PASS rgb_led_blink_flash_sequencer_top");
    end else begin
      $display("FAIL rgb_led_blink_flash_sequencer_top");
    end
    $finish;
  end

endmodule
